// ===== rtl/xst_pkg.sv =====
// shared constants and helpers for the session token block
// cipher round function, symbol alphabet and configuration register indexes
`default_nettype none

package xst_pkg;

  localparam int unsigned CIPHER_CYCLES_DEF = 64;
  localparam logic [31:0] XTEA_DELTA = 32'h9e3779b9;
  localparam logic [3:0]  TOKEN_MAX = 4'd11;
  localparam logic [3:0]  MAX_CHARS_RST = 4'd11;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS  = 3'd4;

  typedef logic [3:0][31:0] key_t;

  // mixing function applied to one half of the block
  function automatic logic [31:0] mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // 64-symbol alphabet: digits, upper case, lower case, underscore, dash
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd10) begin
      c = 8'(v) + 8'h30;
    end else if (v < 6'd36) begin
      c = 8'(v) - 8'd10 + 8'h41;
    end else if (v < 6'd62) begin
      c = 8'(v) - 8'd36 + 8'h61;
    end else if (v == 6'd62) begin
      c = 8'h5f;
    end else begin
      c = 8'h2d;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/xst_cipher.sv =====
// xtea encipher pipeline, one half-round per register stage
// depends on xst_pkg for the round function and delta
`default_nettype none

module xst_cipher #(
  parameter int unsigned CIPHER_CYCLES = xst_pkg::CIPHER_CYCLES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              in_valid_i,
  input  wire logic [31:0]       pnum_i,
  input  wire xst_pkg::key_t     key_i,
  output logic                   out_valid_o,
  output logic [63:0]            cipher_o
);

  localparam int unsigned NSTG = 2 * CIPHER_CYCLES;

  logic [31:0] a_q [NSTG];
  logic [31:0] b_q [NSTG];
  logic        vld_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int unsigned CYC = s / 2;
    localparam bit HALF = (s % 2) == 1;
    // running sum is fixed per stage, so the key word is picked at elaboration
    localparam logic [31:0] SUM =
      32'(64'(CYC + (HALF ? 1 : 0)) * 64'(xst_pkg::XTEA_DELTA));
    localparam logic [1:0] KIDX = HALF ? SUM[12:11] : SUM[1:0];

    logic [31:0] a_in, b_in, a_d, b_d;
    logic        v_in;

    if (s == 0) begin : g_first
      assign a_in = 32'd0;
      assign b_in = pnum_i;
      assign v_in = in_valid_i;
    end else begin : g_rest
      assign a_in = a_q[s-1];
      assign b_in = b_q[s-1];
      assign v_in = vld_q[s-1];
    end

    if (HALF) begin : g_hb
      assign a_d = a_in;
      assign b_d = b_in + (xst_pkg::mix(a_in) ^ (SUM + key_i[KIDX]));
    end else begin : g_ha
      assign a_d = a_in + (xst_pkg::mix(b_in) ^ (SUM + key_i[KIDX]));
      assign b_d = b_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        a_q[s] <= a_d;
        b_q[s] <= b_d;
      end
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign cipher_o    = {a_q[NSTG-1], b_q[NSTG-1]};

endmodule

`default_nettype wire

// ===== rtl/xst_serializer.sv =====
// turns one 64-bit ciphertext into token characters, six bits per character
// depends on xst_pkg for the alphabet and the character limit
`default_nettype none

module xst_serializer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tok_valid_i,
  output logic             tok_ready_o,
  input  wire logic [63:0] cipher_i,
  input  wire logic [3:0]  max_chars_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       char_code_o,
  output logic             empty_token_o,
  output logic             last_char_o,
  output logic [63:0]      cipher_value_o
);

  logic        busy_q, busy_d;
  logic [63:0] cipher_q;
  logic [63:0] rest_q, rest_d;
  logic [3:0]  left_q, left_d;
  logic        empty_q;

  logic        ovld_q, ovld_d;
  logic [7:0]  char_q;
  logic        oempty_q, olast_q;
  logic [63:0] ocipher_q;

  logic        out_take, emit, is_last, load;
  logic [3:0]  lim;

  assign out_take = !ovld_q || out_ready_i;
  assign emit     = busy_q && out_take;
  assign is_last  = empty_q || (rest_q[63:6] == 58'd0) || (left_q == 4'd1);
  assign tok_ready_o = !busy_q || (emit && is_last);
  assign load     = tok_valid_i && tok_ready_o;
  assign lim      = (max_chars_i > xst_pkg::TOKEN_MAX) ? xst_pkg::TOKEN_MAX : max_chars_i;

  always_comb begin
    busy_d = busy_q;
    rest_d = rest_q;
    left_d = left_q;
    if (emit) begin
      rest_d = rest_q >> 6;
      left_d = left_q - 4'd1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      rest_d = cipher_i;
      left_d = lim;
    end
    ovld_d = emit || (ovld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    left_q <= left_d;
    if (load) begin
      cipher_q <= cipher_i;
      empty_q  <= (cipher_i == 64'd0) || (lim == 4'd0);
    end
    if (emit) begin
      char_q    <= empty_q ? 8'd0 : xst_pkg::sym_char(rest_q[5:0]);
      oempty_q  <= empty_q;
      olast_q   <= is_last;
      ocipher_q <= cipher_q;
    end
  end

  assign out_valid_o    = ovld_q;
  assign char_code_o    = char_q;
  assign empty_token_o  = oempty_q;
  assign last_char_o    = olast_q;
  assign cipher_value_o = ocipher_q;

endmodule

`default_nettype wire

// ===== rtl/xst_cipher_wrap_note.sv =====
// configuration register file for the key words and character limit
// depends on xst_pkg for register indexes and reset values
`default_nettype none

module xst_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [xst_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [xst_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output xst_pkg::key_t                            key_o,
  output logic [3:0]                               max_chars_o
);

  xst_pkg::key_t key_q;
  logic [3:0]    max_chars_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      max_chars_q <= xst_pkg::MAX_CHARS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        xst_pkg::CFG_KEY_WORD_0: key_q[0] <= cfg_wdata_i;
        xst_pkg::CFG_KEY_WORD_1: key_q[1] <= cfg_wdata_i;
        xst_pkg::CFG_KEY_WORD_2: key_q[2] <= cfg_wdata_i;
        xst_pkg::CFG_KEY_WORD_3: key_q[3] <= cfg_wdata_i;
        xst_pkg::CFG_MAX_CHARS:  max_chars_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign key_o       = key_q;
  assign max_chars_o = max_chars_q;

endmodule

`default_nettype wire

// ===== rtl/xtea_session_token.sv =====
// Session token generator. Each request carries a 32-bit process number; the
// block {0, number} is enciphered with XTEA (delta 0x9e3779b9, CIPHER_CYCLES
// full XTEA iterations) under the 128-bit key in configuration registers 0..3, and the
// 64-bit ciphertext is emitted as text, six bits per character, lowest first,
// until the rest is zero or max_chars (register 4, clamped to 11) is reached.
// A zero ciphertext or a zero limit gives one result flagged empty. The
// cipher is a pipeline of 2*CIPHER_CYCLES register stages, one half-round
// each, followed by the registered character serializer, which sends one
// result per cycle while the receiver is ready, so that serializer sets the
// sustained rate.
// Write configuration only while no request is in flight.
// depends on xst_pkg, xst_cfg_regs, xst_cipher and xst_serializer
`default_nettype none

module xtea_session_token #(
  parameter int unsigned CIPHER_CYCLES = xst_pkg::CIPHER_CYCLES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [xst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [xst_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [31:0]                    process_number_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [7:0]                          char_code_o,
  output logic                                empty_token_o,
  output logic                                last_char_o,
  output logic [63:0]                         cipher_value_o
);

  xst_pkg::key_t key;
  logic [3:0]    max_chars;
  logic          pipe_vld, tok_ready, adv;
  logic [63:0]   pipe_cipher;

  xst_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key),
    .max_chars_o (max_chars)
  );

  // whole pipeline moves together; it holds only when its last stage waits
  assign adv        = !pipe_vld || tok_ready;
  assign in_ready_o = adv;

  xst_cipher #(
    .CIPHER_CYCLES (CIPHER_CYCLES)
  ) u_cipher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .pnum_i      (process_number_i),
    .key_i       (key),
    .out_valid_o (pipe_vld),
    .cipher_o    (pipe_cipher)
  );

  xst_serializer u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_valid_i    (pipe_vld),
    .tok_ready_o    (tok_ready),
    .cipher_i       (pipe_cipher),
    .max_chars_i    (max_chars),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_code_o    (char_code_o),
    .empty_token_o  (empty_token_o),
    .last_char_o    (last_char_o),
    .cipher_value_o (cipher_value_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_xtea_session_token.sv =====
// testbench for xtea_session_token: queue-fed request driver and result monitor
// checked against an in-bench XTEA cipher and token encoder, depends on xst_pkg
`timescale 1ns / 1ps

module tb_xtea_session_token;

  localparam int unsigned CYCLES = 64;
  localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
  localparam logic [8*64-1:0] TOKEN_ALPHABET =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_-";
  localparam int unsigned LATENCY = 2 * CYCLES + 1;
  localparam int unsigned RX_HOLD_CYCLES = 1200;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0]  chr;
    logic        empty;
    logic        last;
    logic [63:0] cipher;
  } token_char_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [xst_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [xst_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [31:0]                    process_number_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [7:0]                     char_code_o;
  logic                           empty_token_o;
  logic                           last_char_o;
  logic [63:0]                    cipher_value_o;

  // shadow copy of the key and character limit
  logic [31:0] key_q [4];
  logic [3:0]  limit_q;

  logic [31:0] pending_pids [$];
  token_char_t expected_chars [$];

  bit          no_idle = 1'b0;
  int unsigned rx_hold_reqs = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned tokens_sent = 0;
  int unsigned chars_seen = 0;
  int unsigned empties_seen = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_cnt = 0;

  xtea_session_token #(
    .CIPHER_CYCLES(CYCLES)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .process_number_i(process_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .char_code_o     (char_code_o),
    .empty_token_o   (empty_token_o),
    .last_char_o     (last_char_o),
    .cipher_value_o  (cipher_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] xtea_cipher(input logic [31:0] pid);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] sum;
    hi = '0;
    lo = pid;
    sum = '0;
    for (int r = 0; r < CYCLES; r++) begin
      hi = hi + ((((lo << 4) ^ (lo >> 5)) + lo) ^ (sum + key_q[sum[1:0]]));
      sum = sum + GOLDEN_RATIO;
      lo = lo + ((((hi << 4) ^ (hi >> 5)) + hi) ^ (sum + key_q[sum[12:11]]));
    end
    return {hi, lo};
  endfunction

  // expected characters of one token, queued in output order
  task automatic predict_token(input logic [31:0] pid);
    logic [63:0] cipher;
    logic [63:0] rest;
    int unsigned lim;
    int unsigned n;
    token_char_t t;
    cipher = xtea_cipher(pid);
    rest = cipher;
    lim = (limit_q > 4'd11) ? 11 : int'(limit_q);
    n = 0;
    if (rest == '0 || lim == 0) begin
      t = '{chr: 8'h00, empty: 1'b1, last: 1'b1, cipher: cipher};
      expected_chars.push_back(t);
    end else begin
      while (n < lim && rest != '0) begin
        t.chr = TOKEN_ALPHABET[8 * (63 - int'(rest[5:0])) +: 8];
        t.empty = 1'b0;
        t.last = (n + 1 == lim) || ((rest >> 6) == '0);
        t.cipher = cipher;
        expected_chars.push_back(t);
        rest = rest >> 6;
        n++;
      end
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      process_number_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_token(process_number_i);
        tokens_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_pids.size() != 0 && (no_idle || $urandom_range(99) >= 9)) begin
          in_valid_i <= 1'b1;
          process_number_i <= pending_pids.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    token_char_t exp_c;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        chars_seen++;
        if (empty_token_o) empties_seen++;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result got chr=%02h empty=%b last=%b cipher=%016h",
                   $time, char_code_o, empty_token_o, last_char_o, cipher_value_o);
          mismatches++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (exp_c.chr !== char_code_o || exp_c.empty !== empty_token_o ||
              exp_c.last !== last_char_o || exp_c.cipher !== cipher_value_o) begin
            $display("%0t: mismatch exp chr=%02h empty=%b last=%b cipher=%016h", $time,
                     exp_c.chr, exp_c.empty, exp_c.last, exp_c.cipher);
            $display("%0t:          got chr=%02h empty=%b last=%b cipher=%016h", $time,
                     char_code_o, empty_token_o, last_char_o, cipher_value_o);
            mismatches++;
          end
        end
      end
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (rx_hold_reqs != rx_hold_seen) begin
        rx_hold_seen <= rx_hold_reqs;
        rx_hold_left <= RX_HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, expected_chars.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [xst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      xst_pkg::CFG_KEY_WORD_0: key_q[0] = data;
      xst_pkg::CFG_KEY_WORD_1: key_q[1] = data;
      xst_pkg::CFG_KEY_WORD_2: key_q[2] = data;
      xst_pkg::CFG_KEY_WORD_3: key_q[3] = data;
      xst_pkg::CFG_MAX_CHARS:  limit_q = data[3:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_key(input logic [127:0] key);
    write_reg(xst_pkg::CFG_KEY_WORD_0, key[31:0]);
    write_reg(xst_pkg::CFG_KEY_WORD_1, key[63:32]);
    write_reg(xst_pkg::CFG_KEY_WORD_2, key[95:64]);
    write_reg(xst_pkg::CFG_KEY_WORD_3, key[127:96]);
    settings_used++;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_pids.size() != 0 || in_valid_i || expected_chars.size() != 0);
  endtask

  function automatic logic [31:0] random_pid();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return 32'hffff_ffff;
    if (pick < 3) return 32'($urandom_range(255));
    return $urandom();
  endfunction

  task automatic queue_random(input int unsigned count);
    @(negedge clk_i);
    for (int i = 0; i < count; i++) pending_pids.push_back(random_pid());
  endtask

  initial begin
    key_q = '{default: 32'h0};
    limit_q = xst_pkg::MAX_CHARS_RST;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset key and limit, edge values of the process number
    pending_pids = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                     32'h5555_5555, 32'haaaa_aaaa, 32'h7fff_ffff, 32'hffff_fffe,
                     32'h0001_0000, 32'h0000_8000};
    drain();

    // all-ones key, limit above eleven is clamped
    load_key({4{32'hffff_ffff}});
    write_reg(xst_pkg::CFG_MAX_CHARS, 32'd15);
    @(negedge clk_i);
    pending_pids = '{32'h0000_0000, 32'hffff_ffff, 32'h1234_5678};
    drain();

    // zero limit: every token is a single empty result
    write_reg(xst_pkg::CFG_MAX_CHARS, 32'd0);
    @(negedge clk_i);
    pending_pids = '{32'h0000_0000, 32'hffff_ffff, 32'hdead_beef, 32'h0000_0001};
    drain();

    // one character per token
    load_key({$urandom(), $urandom(), $urandom(), $urandom()});
    write_reg(xst_pkg::CFG_MAX_CHARS, 32'd1);
    @(negedge clk_i);
    pending_pids = '{32'h0000_0000, 32'hffff_ffff, 32'h0f0f_0f0f, 32'hf0f0_f0f0};
    drain();

    // receiver stalls long while requests keep coming with no gaps, so the
    // pipeline backs up; the drain afterwards runs with no idling either
    load_key({$urandom(), $urandom(), $urandom(), $urandom()});
    write_reg(xst_pkg::CFG_MAX_CHARS, 32'(xst_pkg::TOKEN_MAX));
    no_idle = 1'b1;
    queue_random(132);
    rx_hold_reqs++;
    drain();
    no_idle = 1'b0;

    // mixed key words, random limit
    load_key({$urandom(), 32'h0, $urandom(), 32'hffff_ffff});
    write_reg(xst_pkg::CFG_MAX_CHARS, 32'($urandom_range(2, 11)));
    queue_random(6);
    drain();

    repeat (LATENCY + 20) @(posedge clk_i);
    @(negedge clk_i);
    if (expected_chars.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_chars.size());
      mismatches++;
    end
    $display("covered %0d tokens, %0d characters (%0d empty) over %0d key/limit settings",
             tokens_sent, chars_seen, empties_seen, settings_used);
    $display("long receiver stall and back-to-back stretch included, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
